@@ hw/rtl/dwt_pkg.sv @@
// ----------------------------------------------------------------------------
// dwt_pkg
// Shared types, constants and helper functions for the word tokenizer.
// ----------------------------------------------------------------------------
package dwt_pkg;

    // width of byte offsets inside the tokenizer
    localparam int POS_W       = 16;
    // width of the offset and length result ports
    localparam int FIELD_W     = 16;
    // depth of the record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [POS_W-1:0]  MAX_POS    = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  NBSP_LEN   = POS_W'(5);
    localparam logic [QPTR_W-1:0] QPTR_LAST  = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL  = QCNT_W'(QUEUE_DEPTH);

    // characters of interest
    localparam logic [7:0] CH_AMP    = 8'h26;  // '&'
    localparam logic [7:0] CH_N      = 8'h6E;  // 'n'
    localparam logic [7:0] CH_B      = 8'h62;  // 'b'
    localparam logic [7:0] CH_S      = 8'h73;  // 's'
    localparam logic [7:0] CH_P      = 8'h70;  // 'p'
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'
    localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
    localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
    localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [7:0] CH_LF     = 8'h0A;  // newline
    localparam logic [7:0] CH_TAB    = 8'h09;  // tab

    // "&nbsp" with the oldest byte in the top position
    localparam logic [39:0] NBSP_PATTERN = {CH_AMP, CH_N, CH_B, CH_S, CH_P};

    // one candidate word
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
    } dwt_word_t;

    // everything one input byte can produce: an ordinary word end and a flush
    typedef struct packed {
        dwt_word_t word;
        dwt_word_t flush;
    } dwt_rec_t;

    // word delimiter set
    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_COMMA)  || (c == CH_SPACE)  || (c == CH_QUOTE) ||
               (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_STAR)  ||
               (c == CH_SLASH)  || (c == CH_COLON)  || (c == CH_DOT)   ||
               (c == CH_LF)     || (c == CH_TAB);
    endfunction

    // length of [b, e), zero when the end lies before the start
    function automatic logic [POS_W-1:0] span_len(input logic [POS_W-1:0] b,
                                                  input logic [POS_W-1:0] e);
        return (e >= b) ? (e - b) : '0;
    endfunction

endpackage

@@ hw/rtl/dwt_front.sv @@
// ----------------------------------------------------------------------------
// dwt_front
// Accepts text bytes, tracks position and entity history, and classifies
// each byte into a record of word ends that is pushed into the queue.
// ----------------------------------------------------------------------------
module dwt_front
    import dwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       text_byte,
    input  logic             skipped,
    input  logic             end_of_text,
    input  logic             queue_full,
    output logic             queue_push,
    output dwt_rec_t         queue_rec
);

    logic [POS_W-1:0] pos_reg,        pos_next;
    logic [POS_W-1:0] word_begin_reg, word_begin_next;
    logic [39:0]      byte_hist_reg,  byte_hist_next;
    logic [4:0]       skip_hist_reg,  skip_hist_next;
    logic             prev_skip_reg,  prev_skip_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] amp_pos;
    logic [POS_W-1:0] word_end;
    logic [POS_W-1:0] begin_after;
    logic             word_ends;
    logic             restart;
    logic             accept;

    assign in_stall   = queue_full;
    assign accept     = in_valid && !queue_full;
    assign queue_push = accept;

    // classify the byte and build its record
    always_comb
    begin
        pos_inc   = (pos_reg == MAX_POS) ? pos_reg : pos_reg + 1'b1;
        amp_pos   = (pos_reg >= NBSP_LEN) ? pos_reg - NBSP_LEN : '0;
        word_ends = 1'b0;
        restart   = 1'b0;
        word_end  = pos_reg;

        priority if (skipped)
        begin
            word_ends = !prev_skip_reg;
            restart   = 1'b1;
        end
        else if (is_delim(text_byte))
        begin
            word_ends = 1'b1;
            restart   = 1'b1;
        end
        else if ((text_byte == CH_SEMI) && (byte_hist_reg == NBSP_PATTERN) &&
                 (skip_hist_reg == 5'b0))
        begin
            word_ends = 1'b1;
            restart   = 1'b1;
            word_end  = amp_pos;
        end
        else
        begin
            // ordinary word byte
            word_ends = 1'b0;
            restart   = 1'b0;
        end

        begin_after = restart ? pos_inc : word_begin_reg;

        queue_rec.word.valid   = word_ends;
        queue_rec.word.start   = word_begin_reg;
        queue_rec.word.length  = span_len(word_begin_reg, word_end);
        queue_rec.flush.valid  = end_of_text;
        queue_rec.flush.start  = begin_after;
        queue_rec.flush.length = span_len(begin_after, pos_inc);
    end

    // text state update, cleared after the last byte of a text
    always_comb
    begin
        pos_next        = pos_reg;
        word_begin_next = word_begin_reg;
        byte_hist_next  = byte_hist_reg;
        skip_hist_next  = skip_hist_reg;
        prev_skip_next  = prev_skip_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                pos_next        = '0;
                word_begin_next = '0;
                byte_hist_next  = '0;
                skip_hist_next  = '0;
                prev_skip_next  = 1'b0;
            end
            else
            begin
                pos_next        = pos_inc;
                word_begin_next = begin_after;
                byte_hist_next  = {byte_hist_reg[31:0], text_byte};
                skip_hist_next  = {skip_hist_reg[3:0], skipped};
                prev_skip_next  = skipped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            word_begin_reg <= '0;
            byte_hist_reg  <= '0;
            skip_hist_reg  <= '0;
            prev_skip_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            word_begin_reg <= word_begin_next;
            byte_hist_reg  <= byte_hist_next;
            skip_hist_reg  <= skip_hist_next;
            prev_skip_reg  <= prev_skip_next;
        end
    end

endmodule

@@ hw/rtl/dwt_queue.sv @@
// ----------------------------------------------------------------------------
// dwt_queue
// Short first-in first-out queue of records between front and back.
// ----------------------------------------------------------------------------
module dwt_queue
    import dwt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dwt_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output dwt_rec_t head_rec,
    output logic     empty
);

    dwt_rec_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == QCNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_rec = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ hw/rtl/dwt_back.sv @@
// ----------------------------------------------------------------------------
// dwt_back
// Pops records, drops words shorter than min_length and sends the rest
// one transaction at a time through the output register.
// ----------------------------------------------------------------------------
module dwt_back
    import dwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               queue_empty,
    input  dwt_rec_t           head_rec,
    output logic               queue_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIELD_W-1:0] word_start,
    output logic [FIELD_W-1:0] word_length,
    output logic               final_flush,
    output logic               last_of_item
);

    logic [7:0]         min_len_reg;
    dwt_rec_t           hold_reg,    hold_next;
    logic               pend_w_reg,  pend_w_next;
    logic               pend_f_reg,  pend_f_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] start_reg,   start_next;
    logic [FIELD_W-1:0] length_reg,  length_next;
    logic               flush_reg,   flush_next;
    logic               last_reg,    last_next;

    logic [POS_W-1:0]   min_len_ext;
    logic               out_free;
    logic               emit_w;
    logic               emit_f;
    logic               pass_w;
    logic               pass_f;

    assign out_valid    = out_valid_reg;
    assign word_start   = start_reg;
    assign word_length  = length_reg;
    assign final_flush  = flush_reg;
    assign last_of_item = last_reg;

    // pick the next pending word and refill the holding record
    always_comb
    begin
        min_len_ext = POS_W'(min_len_reg);
        out_free    = !out_valid_reg || !out_stall;
        emit_w      = out_free && pend_w_reg;
        emit_f      = out_free && !pend_w_reg && pend_f_reg;
        pend_w_next = pend_w_reg && !emit_w;
        pend_f_next = pend_f_reg && !emit_f;
        hold_next   = hold_reg;

        pass_w    = head_rec.word.valid && (head_rec.word.length >= min_len_ext);
        pass_f    = head_rec.flush.valid && (head_rec.flush.length >= min_len_ext);
        queue_pop = !queue_empty && !pend_w_next && !pend_f_next;
        if (queue_pop)
        begin
            hold_next   = head_rec;
            pend_w_next = pass_w;
            pend_f_next = pass_f;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        start_next     = start_reg;
        length_next    = length_reg;
        flush_next     = flush_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = emit_w || emit_f;
            if (emit_f)
            begin
                start_next  = FIELD_W'(hold_reg.flush.start);
                length_next = FIELD_W'(hold_reg.flush.length);
                flush_next  = 1'b1;
                last_next   = 1'b1;
            end
            else
            begin
                start_next  = FIELD_W'(hold_reg.word.start);
                length_next = FIELD_W'(hold_reg.word.length);
                flush_next  = 1'b0;
                last_next   = !pend_f_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= 8'd1;
            pend_w_reg    <= 1'b0;
            pend_f_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_len_reg <= cfg_wr_data;
            end
            pend_w_reg    <= pend_w_next;
            pend_f_reg    <= pend_f_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        start_reg  <= start_next;
        length_reg <= length_next;
        flush_reg  <= flush_next;
        last_reg   <= last_next;
    end

endmodule

@@ hw/rtl/delimiter_word_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// delimiter_word_tokenizer_top
// Word tokenizer: reports start offset and length of each word in a text.
// ----------------------------------------------------------------------------
// Input channel: one text byte per transaction (text_byte, skipped,
// end_of_text), taken when in_valid is high and in_stall is low.
// Output channel: one word per transaction (word_start, word_length,
// final_flush, last_of_item), taken when out_valid is high and out_stall
// is low. A byte gives zero, one or two words; last_of_item marks the last.
// min_length is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Words shorter than min_length are dropped. Throughput: one byte per cycle
// in unless in_stall is high, one word per cycle out unless out_stall is high.
// A byte that produces two words sends them one after the other. A word goes
// through the queue write, the holding record and the output register in turn.
// A four-record queue lets the front keep taking bytes while the receiver
// stalls; in_stall rises only when that queue is full.
// Reset clears all text state, empties the queue and sets min_length to 1.
// ----------------------------------------------------------------------------
module delimiter_word_tokenizer_top
    import dwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         text_byte,
    input  logic               skipped,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIELD_W-1:0] word_start,
    output logic [FIELD_W-1:0] word_length,
    output logic               final_flush,
    output logic               last_of_item
);

    logic     queue_full;
    logic     queue_empty;
    logic     queue_push;
    logic     queue_pop;
    dwt_rec_t push_rec;
    dwt_rec_t head_rec;

    // byte classification
    dwt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .skipped     (skipped),
        .end_of_text (end_of_text),
        .queue_full  (queue_full),
        .queue_push  (queue_push),
        .queue_rec   (push_rec)
    );

    // record queue
    dwt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .push_rec (push_rec),
        .full     (queue_full),
        .pop      (queue_pop),
        .head_rec (head_rec),
        .empty    (queue_empty)
    );

    // filtering and result output
    dwt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .queue_empty  (queue_empty),
        .head_rec     (head_rec),
        .queue_pop    (queue_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .word_start   (word_start),
        .word_length  (word_length),
        .final_flush  (final_flush),
        .last_of_item (last_of_item)
    );

endmodule
